// File: src/kss_pkg.sv
// kss_pkg: shared types and codes for the rank-selection block.
// No dependencies; imported by the top level.
package kss_pkg;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_RANK = 2'd1,
		ERR_DROP = 2'd2
	} err_t;

	localparam int SAMPLE_W = 32;
	localparam int RANK_W   = 10;

endpackage

// File: src/kss_cell.sv
// kss_cell: one compare cell of the selection chain.
// Holds one candidate and counts the streamed elements that precede it.
// Depends on kss_pkg.
module kss_cell #(
	parameter int CW = 11
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 shift_en,
	input  logic signed [kss_pkg::SAMPLE_W-1:0]  cand_val_in,
	input  logic [CW-1:0]                        cand_idx_in,
	input  logic                                 cand_ok_in,
	output logic signed [kss_pkg::SAMPLE_W-1:0]  cand_val,
	output logic [CW-1:0]                        cand_idx,
	output logic                                 cand_ok,
	input  logic                                 str_valid_in,
	input  logic signed [kss_pkg::SAMPLE_W-1:0]  str_val_in,
	input  logic [CW-1:0]                        str_idx_in,
	output logic                                 str_valid,
	output logic signed [kss_pkg::SAMPLE_W-1:0]  str_val,
	output logic [CW-1:0]                        str_idx,
	input  logic [kss_pkg::RANK_W-1:0]           rank,
	output logic                                 hit
);
	import kss_pkg::*;

	localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

	logic signed [SAMPLE_W-1:0] cand_val_q;
	logic [CW-1:0]              cand_idx_q;
	logic                       cand_ok_q;
	logic [CW-1:0]              count_q;
	logic                       str_valid_q;
	logic signed [SAMPLE_W-1:0] str_val_q;
	logic [CW-1:0]              str_idx_q;
	logic                       precedes;

	// value order, equal values by load order
	assign precedes = (str_val_in < cand_val_q) ||
		((str_val_in == cand_val_q) && (str_idx_in < cand_idx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_ok_q   <= 1'b0;
			count_q     <= '0;
			str_valid_q <= 1'b0;
		end else begin
			str_valid_q <= str_valid_in;
			if (shift_en) begin
				cand_ok_q <= cand_ok_in;
				count_q   <= '0;
			end else if (str_valid_in && precedes) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		str_val_q <= str_val_in;
		str_idx_q <= str_idx_in;
		if (shift_en) begin
			cand_val_q <= cand_val_in;
			cand_idx_q <= cand_idx_in;
		end
	end

	assign cand_val  = cand_val_q;
	assign cand_idx  = cand_idx_q;
	assign cand_ok   = cand_ok_q;
	assign str_valid = str_valid_q;
	assign str_val   = str_val_q;
	assign str_idx   = str_idx_q;
	assign hit       = cand_ok_q && (CMPW'(count_q) == CMPW'(rank));

endmodule

// File: src/kth_smallest_select.sv
// kth_smallest_select: top level, element store, pass sequencer and cell chain.
// Depends on kss_pkg and kss_cell.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+----------------------
//  input   | sample, is_last, rank                     | in_valid && in_ready
//  output  | chosen_value, chosen_position, error      | out_valid && out_ready
//
// Loading writes each stored element through one memory write port.
// Selection runs in passes of NUM_CELLS candidates: a candidate phase shifts
// them into the chain, a stream phase streams all n stored elements past it
// (one memory read a cycle), then a drain phase and a check step.
// Up to ceil(n/NUM_CELLS) passes; a set with an error result takes no passes.
// Reset clears the count, the overflow flag, the sequencer and the result
// valid flag; the store itself and the result data are not cleared.
// The input stalls during selection, and a last element also stalls while a
// previous result has not been taken.
module kth_smallest_select #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int NUM_CELLS    = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [kss_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 is_last,
	input  logic [kss_pkg::RANK_W-1:0]           rank,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [kss_pkg::SAMPLE_W-1:0]  chosen_value,
	output logic [kss_pkg::RANK_W-1:0]           chosen_position,
	output logic [1:0]                           error
);
	import kss_pkg::*;

	localparam int AW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW   = $clog2(MAX_ELEMENTS + 1);
	localparam int BW   = CW + 1;
	localparam int NCW  = $clog2(NUM_CELLS + 2);
	localparam int SW   = (CW > NCW) ? CW : NCW;
	localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

	typedef enum logic [4:0] {
		S_LOAD   = 5'b00001,
		S_CAND   = 5'b00010,
		S_STREAM = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_CHECK  = 5'b10000
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              cnt_q;      // elements stored in current set
	logic                       ovf_q;
	logic [CW-1:0]              n_q;        // set size under selection
	logic [RANK_W-1:0]          rank_q;
	logic [BW-1:0]              base_q;     // first candidate of this pass
	logic [SW-1:0]              step_q;

	logic signed [SAMPLE_W-1:0] mem [MAX_ELEMENTS];
	logic signed [SAMPLE_W-1:0] rd_data_q;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic                       rd_shift_q;
	logic                       rd_str_q;
	logic                       rd_ok_q;
	logic [CW-1:0]              rd_idx_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_value_q;
	logic [RANK_W-1:0]          out_pos_q;
	err_t                       out_err_q;

	logic                       accept;
	logic                       stored;
	logic [CW-1:0]              new_n;
	err_t                       load_err;
	logic [BW-1:0]              cand_sum;

	logic signed [SAMPLE_W-1:0] cand_val_w  [NUM_CELLS+1];
	logic [CW-1:0]              cand_idx_w  [NUM_CELLS+1];
	logic                       cand_ok_w   [NUM_CELLS+1];
	logic                       str_valid_w [NUM_CELLS+1];
	logic signed [SAMPLE_W-1:0] str_val_w   [NUM_CELLS+1];
	logic [CW-1:0]              str_idx_w   [NUM_CELLS+1];
	logic [NUM_CELLS-1:0]       hit_w;
	logic                       any_hit;
	logic signed [SAMPLE_W-1:0] sel_val;
	logic [CW-1:0]              sel_idx;

	// ---------------- load side ----------------
	// while loading, a last element waits only if the result register is still occupied
	assign in_ready = (state_q == S_LOAD) && (!out_valid_q || !is_last);
	assign accept   = in_valid && in_ready;
	assign stored   = cnt_q < CW'(MAX_ELEMENTS);
	assign new_n    = cnt_q + CW'(stored);

	// dropped elements win over a bad rank
	always_comb begin
		if (ovf_q || !stored) begin
			load_err = ERR_DROP;
		end else if (CMPW'(rank) >= CMPW'(new_n)) begin
			load_err = ERR_RANK;
		end else begin
			load_err = ERR_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && stored) begin
			mem[cnt_q[AW-1:0]] <= sample;
		end
	end

	// ---------------- read port ----------------
	assign cand_sum = base_q + BW'(step_q);
	assign rd_en    = (state_q == S_CAND) || (state_q == S_STREAM);
	assign rd_addr  = (state_q == S_CAND) ? cand_sum[AW-1:0] : step_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		rd_idx_q <= (state_q == S_CAND) ? CW'(cand_sum) : CW'(step_q);
		rd_ok_q  <= cand_sum < BW'(n_q);
	end

	// ---------------- cell chain ----------------
	assign cand_val_w[0]  = rd_data_q;
	assign cand_idx_w[0]  = rd_idx_q;
	assign cand_ok_w[0]   = rd_ok_q;
	assign str_valid_w[0] = rd_str_q;
	assign str_val_w[0]   = rd_data_q;
	assign str_idx_w[0]   = rd_idx_q;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		kss_cell #(.CW(CW)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.shift_en     (rd_shift_q),
			.cand_val_in  (cand_val_w[g]),
			.cand_idx_in  (cand_idx_w[g]),
			.cand_ok_in   (cand_ok_w[g]),
			.cand_val     (cand_val_w[g+1]),
			.cand_idx     (cand_idx_w[g+1]),
			.cand_ok      (cand_ok_w[g+1]),
			.str_valid_in (str_valid_w[g]),
			.str_val_in   (str_val_w[g]),
			.str_idx_in   (str_idx_w[g]),
			.str_valid    (str_valid_w[g+1]),
			.str_val      (str_val_w[g+1]),
			.str_idx      (str_idx_w[g+1]),
			.rank         (rank_q),
			.hit          (hit_w[g])
		);
	end

	// order is total, so at most one cell hits: plain OR-mux
	always_comb begin
		sel_val = '0;
		sel_idx = '0;
		for (int j = 0; j < NUM_CELLS; j++) begin
			if (hit_w[j]) begin
				sel_val = sel_val | cand_val_w[j+1];
				sel_idx = sel_idx | cand_idx_w[j+1];
			end
		end
	end
	assign any_hit = |hit_w;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			step_q      <= '0;
			base_q      <= '0;
			rd_shift_q  <= 1'b0;
			rd_str_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_shift_q <= (state_q == S_CAND);
			rd_str_q   <= (state_q == S_STREAM);
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (is_last) begin
							cnt_q  <= '0;
							ovf_q  <= 1'b0;
							step_q <= '0;
							base_q <= '0;
							if (load_err != ERR_OK) begin
								out_valid_q <= 1'b1;
							end else begin
								state_q <= S_CAND;
							end
						end else begin
							cnt_q <= new_n;
							ovf_q <= ovf_q || !stored;
						end
					end
				end
				S_CAND: begin
					if (step_q == SW'(NUM_CELLS - 1)) begin
						step_q  <= '0;
						state_q <= S_STREAM;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				S_STREAM: begin
					if (SW'(step_q) == SW'(n_q) - SW'(1)) begin
						step_q  <= '0;
						state_q <= S_DRAIN;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				S_DRAIN: begin
					if (step_q == SW'(NUM_CELLS)) begin
						step_q  <= '0;
						state_q <= S_CHECK;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				S_CHECK: begin
					if (any_hit) begin
						out_valid_q <= 1'b1;
						state_q     <= S_LOAD;
					end else begin
						base_q  <= base_q + BW'(NUM_CELLS);
						state_q <= S_CAND;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// set-level payload and result data
	always_ff @(posedge clk) begin
		if (accept && is_last) begin
			n_q    <= new_n;
			rank_q <= rank;
			if (load_err != ERR_OK) begin
				out_value_q <= '0;
				out_pos_q   <= '0;
				out_err_q   <= load_err;
			end
		end
		if ((state_q == S_CHECK) && any_hit) begin
			out_value_q <= sel_val;
			out_pos_q   <= RANK_W'(sel_idx);
			out_err_q   <= ERR_OK;
		end
	end

	assign out_valid       = out_valid_q;
	assign chosen_value    = out_value_q;
	assign chosen_position = out_pos_q;
	assign error           = out_err_q;

	// ---------------- checks ----------------
	// the result register is empty whenever a selection finishes
	a_check_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> !out_valid_q)
		else $error("selection finished while a result was still held");

	// the answer is found before the candidates run out
	a_base_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CAND) |-> (base_q < BW'(n_q)))
		else $error("selection pass started past the end of the set");

	// total order: never two cells at the same rank
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> $onehot0(hit_w))
		else $error("more than one candidate matched the rank");

	// a result appears only from a check or from an error on the last element
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |->
			($past(state_q == S_CHECK) || $past(accept && is_last)))
		else $error("result appeared without a cause");

endmodule
